// ===== rtl/hbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Shared types, register indexes and reset values of the peer liveness monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package hbm_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned ID_W      = 11;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned RCV_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  typedef enum logic [1:0] {
    ST_INIT       = 2'd0,
    ST_ONLINE     = 2'd1,
    ST_OFFLINE    = 2'd2,
    ST_RECOVERING = 2'd3
  } peer_state_t;

  typedef enum logic [1:0] {
    FC_DATA      = 2'd0,
    FC_HEARTBEAT = 2'd1,
    FC_OTHER     = 2'd2,
    FC_NONE      = 2'd3
  } frame_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_ID    = 2'd0,
    CFG_HB_ID      = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_RECOVERY   = 2'd3
  } cfg_index_t;

  localparam logic [ID_W-1:0]  RST_DATA_ID  = 11'h321;
  localparam logic [ID_W-1:0]  RST_HB_ID    = 11'h701;
  localparam logic [TMO_W-1:0] RST_TIMEOUT  = 16'd1500;
  localparam logic [RCV_W-1:0] RST_RECOVERY = 4'd3;

  localparam logic KIND_FRAME = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/hbm_if.sv =====
// ----------------------------------------------------------------------------
// Heartbeat monitor channel interfaces
// Valid/ready channels for input transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbm_in_if
  import hbm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [NOW_W-1:0]     now_ms;
  logic [ID_W-1:0]      frame_id;
  logic [LEN_W-1:0]     frame_len;
  logic [PAYLOAD_W-1:0] frame_payload;

  modport source (output valid, kind, now_ms, frame_id, frame_len, frame_payload,
                  input ready);
  modport sink   (input valid, kind, now_ms, frame_id, frame_len, frame_payload,
                  output ready);
endinterface

interface hbm_out_if
  import hbm_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               peer_state;
  logic                     peer_online;
  logic [1:0]               frame_class;
  logic [NOW_W-1:0]         heartbeat_age;
  logic [COUNTER_WIDTH-1:0] heartbeat_total;
  logic [COUNTER_WIDTH-1:0] timeout_total;
  logic [COUNTER_WIDTH-1:0] state_change_total;
  logic [COUNTER_WIDTH-1:0] data_frame_total;
  logic [COUNTER_WIDTH-1:0] unexpected_total;
  logic [7:0]               last_data_counter;
  logic [LEN_W-1:0]         last_data_len;
  logic [PAYLOAD_W-1:0]     last_data_payload;

  modport source (output valid, peer_state, peer_online, frame_class, heartbeat_age,
                  heartbeat_total, timeout_total, state_change_total,
                  data_frame_total, unexpected_total, last_data_counter,
                  last_data_len, last_data_payload,
                  input ready);
  modport sink   (input valid, peer_state, peer_online, frame_class, heartbeat_age,
                  heartbeat_total, timeout_total, state_change_total,
                  data_frame_total, unexpected_total, last_data_counter,
                  last_data_len, last_data_payload,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/hbm_classify.sv =====
// ----------------------------------------------------------------------------
// Heartbeat monitor frame classifier
// Sorts a transaction into data, heartbeat, other frame or idle check.
// ----------------------------------------------------------------------------
`default_nettype none

module hbm_classify
  import hbm_pkg::*;
(
  input  wire logic            kind,
  input  wire logic [ID_W-1:0] frame_id,
  input  wire logic [ID_W-1:0] data_id,
  input  wire logic [ID_W-1:0] hb_id,
  output frame_class_t         frame_class
);

  always_comb begin
    priority if (kind != KIND_FRAME) begin
      frame_class = FC_NONE;
    end else if (frame_id == data_id) begin
      frame_class = FC_DATA;
    end else if (frame_id == hb_id) begin
      frame_class = FC_HEARTBEAT;
    end else begin
      frame_class = FC_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/heartbeat_node_liveness_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Heartbeat node liveness monitor
// Tracks one peer's heartbeats, data frames and timeouts, one result per input.
// ----------------------------------------------------------------------------
// Latency: a result is registered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the output register stalls input only
// while a result waits and out ready is low.
// Reset: synchronous active-low rst_n restores register defaults and clears
// the peer state, heartbeat tracking and all event counters.
`default_nettype none

module heartbeat_node_liveness_monitor_core
  import hbm_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  hbm_in_if.sink                    in_chan,
  hbm_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

  logic [ID_W-1:0]  data_id_r;
  logic [ID_W-1:0]  hb_id_r;
  logic [TMO_W-1:0] timeout_r;
  logic [RCV_W-1:0] recovery_r;

  peer_state_t      peer_state_r, peer_state_nxt;
  logic             seen_r, seen_nxt;
  logic [NOW_W-1:0] last_hb_r, last_hb_nxt;
  logic             latched_r, latched_nxt;
  logic [RCV_W-1:0] rcount_r, rcount_nxt;

  logic [COUNTER_WIDTH-1:0] hb_cnt_r, hb_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] to_cnt_r, to_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] ch_cnt_r, ch_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] df_cnt_r, df_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] ux_cnt_r, ux_cnt_nxt;

  logic [PAYLOAD_W-1:0] st_payload_r, st_payload_nxt;
  logic [LEN_W-1:0]     st_len_r, st_len_nxt;
  logic [7:0]           st_counter_r, st_counter_nxt;
  logic [NOW_W-1:0]     age_r, age_nxt;
  frame_class_t         fclass_r;
  logic                 out_valid_r;

  frame_class_t fclass;
  logic         accept;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  hbm_classify u_classify (
    .kind        (in_chan.kind),
    .frame_id    (in_chan.frame_id),
    .data_id     (data_id_r),
    .hb_id       (hb_id_r),
    .frame_class (fclass)
  );

  always_comb begin
    logic [LEN_W-1:0] len_c;
    logic [RCV_W-1:0] rc_inc;
    peer_state_t      mid_state;
    logic [1:0]       changes;

    len_c          = (in_chan.frame_len > MAX_LEN) ? MAX_LEN : in_chan.frame_len;
    rc_inc         = rcount_r + RCV_W'(1);
    mid_state      = peer_state_r;
    seen_nxt       = seen_r;
    last_hb_nxt    = last_hb_r;
    latched_nxt    = latched_r;
    rcount_nxt     = rcount_r;
    hb_cnt_nxt     = hb_cnt_r;
    to_cnt_nxt     = to_cnt_r;
    df_cnt_nxt     = df_cnt_r;
    ux_cnt_nxt     = ux_cnt_r;
    st_payload_nxt = st_payload_r;
    st_len_nxt     = st_len_r;
    st_counter_nxt = st_counter_r;

    unique case (fclass)
      FC_DATA: begin
        df_cnt_nxt     = df_cnt_r + CNT_ONE;
        st_len_nxt     = len_c;
        st_counter_nxt = (len_c != '0) ? in_chan.frame_payload[7:0] : 8'd0;
        st_payload_nxt = in_chan.frame_payload;
      end
      FC_HEARTBEAT: begin
        hb_cnt_nxt  = hb_cnt_r + CNT_ONE;
        seen_nxt    = 1'b1;
        last_hb_nxt = in_chan.now_ms;
        latched_nxt = 1'b0;
        unique case (peer_state_r)
          ST_OFFLINE: begin
            rcount_nxt = RCV_W'(1);
            mid_state  = ST_RECOVERING;
          end
          ST_RECOVERING: begin
            rcount_nxt = rc_inc;
            if (rc_inc >= recovery_r) begin
              rcount_nxt = '0;
              mid_state  = ST_ONLINE;
            end
          end
          default: begin
            rcount_nxt = '0;
            mid_state  = ST_ONLINE;
          end
        endcase
      end
      FC_OTHER: begin
        ux_cnt_nxt = ux_cnt_r + CNT_ONE;
      end
      FC_NONE: begin
      end
    endcase

    peer_state_nxt = mid_state;
    if (!seen_nxt) begin
      age_nxt        = '0;
      peer_state_nxt = ST_INIT;
    end else begin
      age_nxt = in_chan.now_ms - last_hb_nxt;
      if (age_nxt > {{(NOW_W-TMO_W){1'b0}}, timeout_r}) begin
        if (!latched_nxt) begin
          to_cnt_nxt  = to_cnt_r + CNT_ONE;
          latched_nxt = 1'b1;
        end
        rcount_nxt     = '0;
        peer_state_nxt = ST_OFFLINE;
      end
    end

    changes    = 2'((mid_state != peer_state_r) ? 1 : 0)
               + 2'((peer_state_nxt != mid_state) ? 1 : 0);
    ch_cnt_nxt = ch_cnt_r + COUNTER_WIDTH'(changes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_id_r    <= RST_DATA_ID;
      hb_id_r      <= RST_HB_ID;
      timeout_r    <= RST_TIMEOUT;
      recovery_r   <= RST_RECOVERY;
      peer_state_r <= ST_INIT;
      seen_r       <= 1'b0;
      last_hb_r    <= '0;
      latched_r    <= 1'b0;
      rcount_r     <= '0;
      hb_cnt_r     <= '0;
      to_cnt_r     <= '0;
      ch_cnt_r     <= '0;
      df_cnt_r     <= '0;
      ux_cnt_r     <= '0;
      st_payload_r <= '0;
      st_len_r     <= '0;
      st_counter_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_idx))
          CFG_DATA_ID:  data_id_r  <= cfg_wdata[ID_W-1:0];
          CFG_HB_ID:    hb_id_r    <= cfg_wdata[ID_W-1:0];
          CFG_TIMEOUT:  timeout_r  <= cfg_wdata[TMO_W-1:0];
          CFG_RECOVERY: recovery_r <= cfg_wdata[RCV_W-1:0];
        endcase
      end
      if (accept) begin
        peer_state_r <= peer_state_nxt;
        seen_r       <= seen_nxt;
        last_hb_r    <= last_hb_nxt;
        latched_r    <= latched_nxt;
        rcount_r     <= rcount_nxt;
        hb_cnt_r     <= hb_cnt_nxt;
        to_cnt_r     <= to_cnt_nxt;
        ch_cnt_r     <= ch_cnt_nxt;
        df_cnt_r     <= df_cnt_nxt;
        ux_cnt_r     <= ux_cnt_nxt;
        st_payload_r <= st_payload_nxt;
        st_len_r     <= st_len_nxt;
        st_counter_r <= st_counter_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      age_r    <= age_nxt;
      fclass_r <= fclass;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.peer_state         = peer_state_r;
  assign out_chan.peer_online        = (peer_state_r == ST_ONLINE);
  assign out_chan.frame_class        = fclass_r;
  assign out_chan.heartbeat_age      = age_r;
  assign out_chan.heartbeat_total    = hb_cnt_r;
  assign out_chan.timeout_total      = to_cnt_r;
  assign out_chan.state_change_total = ch_cnt_r;
  assign out_chan.data_frame_total   = df_cnt_r;
  assign out_chan.unexpected_total   = ux_cnt_r;
  assign out_chan.last_data_counter  = st_counter_r;
  assign out_chan.last_data_len      = st_len_r;
  assign out_chan.last_data_payload  = st_payload_r;

`ifndef SYNTHESIS
  a_init_age_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (peer_state_r == ST_INIT) |-> (age_r == '0))
    else $error("Result in INIT state carries a nonzero heartbeat age.");

  a_hb_clears_latch : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (fclass == FC_HEARTBEAT) |=> !latched_r && seen_r && (age_r == '0))
    else $error("Heartbeat transaction did not clear the timeout latch.");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r)
    else $error("Input stalled while the output register is empty.");

  a_latch_offline : assert property (@(posedge clk) disable iff (!rst_n)
    latched_r && (peer_state_r != ST_OFFLINE) |-> !$stable(hb_cnt_r) || !$past(latched_r))
    else $error("Timeout latch set while the peer is not offline.");

  a_recovery_range : assert property (@(posedge clk) disable iff (!rst_n)
    (peer_state_r != ST_RECOVERING) |-> (rcount_r == '0))
    else $error("Recovery count nonzero outside RECOVERING state.");
`endif

endmodule

`default_nettype wire
